[rtl/piecewise_linear_interpolator_defines.svh]
// Assertion macros for the piecewise linear interpolator.
// Included by the top level; depends on nothing else.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PLINT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define PLINT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/plint_pkg.sv]
// Shared types and constants for the piecewise linear interpolator.
// No dependencies; used by the top level and the serial divider.
package plint_pkg;

   // Fixed field widths of the command and configuration ports
   localparam int KNOT_INDEX_WIDTH = 4;
   localparam int KNOT_COUNT_WIDTH = 5;
   localparam int MIN_KNOTS        = 2;

   // Command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   // Quotient digit produced per divider step (0, 1 or 2)
   localparam int DIGIT_WIDTH = 2;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_ZERO = 2'd0;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_ONE  = 2'd1;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_TWO  = 2'd2;

   // Evaluate sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_WALK,
      ST_PREP,
      ST_DIV,
      ST_DONE
   } plint_state_type;

endpackage

[rtl/plint_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module plint_ram #(
   parameter int DATA_WIDTH = 32,
   parameter int DEPTH      = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]    wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0]    rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/plint_muldiv.sv]
// Bit-serial unit computing floor(a * b / d) for 0 < b <= d, one bit of a per cycle.
// Depends on plint_pkg for the quotient digit codes.
module plint_muldiv #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] a,
   input  logic [VALUE_WIDTH-1:0] b,
   input  logic [VALUE_WIDTH-1:0] d,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] quot
);

   localparam int TW   = VALUE_WIDTH + 2;
   localparam int CNTW = $clog2(VALUE_WIDTH);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNTW-1:0]        cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] a_sr_ff, a_sr_in;
   logic [VALUE_WIDTH-1:0] b_ff, b_in;
   logic [VALUE_WIDTH-1:0] d_ff, d_in;
   logic [VALUE_WIDTH-1:0] r_ff, r_in;
   logic [VALUE_WIDTH-1:0] q_ff, q_in;

   logic [TW-1:0]                     t_sum;
   logic [TW:0]                       s1_diff;
   logic [TW:0]                       s2_diff;
   logic [plint_pkg::DIGIT_WIDTH-1:0] digit;
   logic [VALUE_WIDTH-1:0]            r_step;

   // One step: remainder doubles, takes b in if the bit of a is set, then
   // drops zero, one or two multiples of d (it stays below 3d)
   always_comb begin
      t_sum   = TW'({r_ff, 1'b0}) + (a_sr_ff[VALUE_WIDTH-1] ? TW'(b_ff) : '0);
      s1_diff = (TW+1)'(t_sum) - (TW+1)'(d_ff);
      s2_diff = (TW+1)'(t_sum) - (TW+1)'({d_ff, 1'b0});
      if (!s2_diff[TW]) begin
         digit  = plint_pkg::DIGIT_TWO;
         r_step = s2_diff[VALUE_WIDTH-1:0];
      end else if (!s1_diff[TW]) begin
         digit  = plint_pkg::DIGIT_ONE;
         r_step = s1_diff[VALUE_WIDTH-1:0];
      end else begin
         digit  = plint_pkg::DIGIT_ZERO;
         r_step = t_sum[VALUE_WIDTH-1:0];
      end
   end

   // Load operands on start, advance one bit a cycle while busy
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_sr_in = a_sr_ff;
      b_in    = b_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_sr_in = a;
         b_in    = b;
         d_in    = d;
         r_in    = '0;
         q_in    = '0;
      end else if (busy_ff) begin
         a_sr_in = {a_sr_ff[VALUE_WIDTH-2:0], 1'b0};
         r_in    = r_step;
         q_in    = {q_ff[VALUE_WIDTH-2:0], 1'b0} + VALUE_WIDTH'(digit);
         cnt_in  = cnt_ff + CNTW'(1);
         if (cnt_ff == CNTW'(VALUE_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Operand and partial result registers
   always_ff @(posedge clock) begin
      a_sr_ff <= a_sr_in;
      b_ff    <= b_in;
      d_ff    <= d_in;
      r_ff    <= r_in;
      q_ff    <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

[rtl/piecewise_linear_interpolator.sv]
// Piecewise linear interpolator. A load beat writes one knot (x, y) into the
// knot table and returns nothing. An evaluate beat clamps to the first or
// last knot's y, or walks the table to the first knot whose x is not below
// the query and interpolates y0 + (q-x0)*(y1-y0)/(x1-x0), truncated toward
// zero. The table sits in one RAM with a single registered read port, so the
// walk reads the knots one after another, and the fraction comes from a
// bit-serial multiply-divide. An evaluate compares the query with the first
// knot, then with the last knot, and only then walks the table and starts
// the divider; the next beat can be taken in the cycle the result appears.
// A stalled result side holds a finished evaluate until the output register
// frees. One evaluate is in flight at a time; loads and evaluates are
// accepted while a finished result waits on the rsp side.
// Knots must be written before they are read.
// Depends on plint_pkg, plint_ram, plint_muldiv and the assertion macro header.
`include "piecewise_linear_interpolator_defines.svh"

module piecewise_linear_interpolator #(
   parameter int MAX_KNOTS   = 16,
   parameter int VALUE_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_command,
   input  logic [plint_pkg::KNOT_INDEX_WIDTH-1:0]  req_knot_index,
   input  logic signed [VALUE_WIDTH-1:0]           req_knot_x,
   input  logic signed [VALUE_WIDTH-1:0]           req_knot_y,
   input  logic signed [VALUE_WIDTH-1:0]           req_query_x,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [VALUE_WIDTH-1:0]           rsp_result_y,
   input  logic                                    csr_write_en,
   input  logic [plint_pkg::KNOT_COUNT_WIDTH-1:0]  csr_write_data
);

   localparam int IDXW = $clog2(MAX_KNOTS);
   localparam int CW   = (IDXW + 1 > plint_pkg::KNOT_COUNT_WIDTH) ?
                         IDXW + 1 : plint_pkg::KNOT_COUNT_WIDTH;
   localparam int RW   = 2 * VALUE_WIDTH;

   plint_pkg::plint_state_type state_ff, state_in;

   logic [plint_pkg::KNOT_COUNT_WIDTH-1:0] knot_count_ff, knot_count_in;
   logic signed [VALUE_WIDTH-1:0]          query_ff, query_in;
   logic [IDXW-1:0]                        idx_ff, idx_in;
   logic signed [VALUE_WIDTH-1:0]          prev_x_ff, prev_x_in;
   logic signed [VALUE_WIDTH-1:0]          prev_y_ff, prev_y_in;
   logic signed [VALUE_WIDTH-1:0]          cur_x_ff, cur_x_in;
   logic signed [VALUE_WIDTH-1:0]          cur_y_ff, cur_y_in;
   logic                                   neg_ff, neg_in;
   logic [VALUE_WIDTH-1:0]                 res_ff, res_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]                 rsp_result_y_ff, rsp_result_y_in;

   logic                          req_accept;
   logic                          rsp_free;
   logic [CW-1:0]                 count_ext;
   logic [CW-1:0]                 load_idx_ext;
   logic [IDXW-1:0]               last_idx;
   logic                          ram_wr_en;
   logic [IDXW-1:0]               ram_rd_addr;
   logic [RW-1:0]                 ram_rd_data;
   logic signed [VALUE_WIDTH-1:0] rd_x;
   logic signed [VALUE_WIDTH-1:0] rd_y;
   logic                          walk_more;
   logic signed [VALUE_WIDTH:0]   diff_d;
   logic signed [VALUE_WIDTH:0]   diff_b;
   logic signed [VALUE_WIDTH:0]   diff_up;
   logic signed [VALUE_WIDTH:0]   diff_down;
   logic                          md_start;
   logic [VALUE_WIDTH-1:0]        md_a;
   logic [VALUE_WIDTH-1:0]        md_b;
   logic [VALUE_WIDTH-1:0]        md_d;
   logic                          md_done;
   logic [VALUE_WIDTH-1:0]        md_quot;

   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Clamp the knot count and derive the last knot in use
   always_comb begin
      count_ext = CW'(knot_count_ff);
      if (count_ext < CW'(plint_pkg::MIN_KNOTS)) begin
         last_idx = IDXW'(plint_pkg::MIN_KNOTS - 1);
      end else if (count_ext > CW'(MAX_KNOTS)) begin
         last_idx = IDXW'(MAX_KNOTS - 1);
      end else begin
         last_idx = IDXW'(count_ext - CW'(1));
      end
   end

   // Drop loads aimed beyond the table
   assign load_idx_ext = CW'(req_knot_index);
   assign ram_wr_en    = req_accept && (req_command == plint_pkg::CMD_LOAD) &&
                         (load_idx_ext < CW'(MAX_KNOTS));

   // Knot table: x in the upper half, y in the lower half
   plint_ram #(
      .DATA_WIDTH (RW),
      .DEPTH      (MAX_KNOTS)
   ) u_knot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (load_idx_ext[IDXW-1:0]),
      .wr_data ({req_knot_x, req_knot_y}),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_x      = $signed(ram_rd_data[RW-1:VALUE_WIDTH]);
   assign rd_y      = $signed(ram_rd_data[VALUE_WIDTH-1:0]);
   assign walk_more = (query_ff > rd_x) && (idx_ff != last_idx);

   // Segment operands for the divider
   always_comb begin
      diff_d    = (VALUE_WIDTH+1)'(cur_x_ff) - (VALUE_WIDTH+1)'(prev_x_ff);
      diff_b    = (VALUE_WIDTH+1)'(query_ff) - (VALUE_WIDTH+1)'(prev_x_ff);
      diff_up   = (VALUE_WIDTH+1)'(cur_y_ff) - (VALUE_WIDTH+1)'(prev_y_ff);
      diff_down = (VALUE_WIDTH+1)'(prev_y_ff) - (VALUE_WIDTH+1)'(cur_y_ff);
      md_d      = diff_d[VALUE_WIDTH-1:0];
      md_b      = diff_b[VALUE_WIDTH-1:0];
      md_a      = diff_up[VALUE_WIDTH] ? diff_down[VALUE_WIDTH-1:0] :
                                         diff_up[VALUE_WIDTH-1:0];
   end

   plint_muldiv #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .a     (md_a),
      .b     (md_b),
      .d     (md_d),
      .done  (md_done),
      .quot  (md_quot)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         plint_pkg::ST_IDLE: begin
            if (req_accept && req_command == plint_pkg::CMD_EVAL) begin
               state_in = plint_pkg::ST_FIRST;
            end
         end
         plint_pkg::ST_FIRST: begin
            state_in = (query_ff <= rd_x) ? plint_pkg::ST_DONE : plint_pkg::ST_LAST;
         end
         plint_pkg::ST_LAST: begin
            state_in = (query_ff >= rd_x) ? plint_pkg::ST_DONE : plint_pkg::ST_WALK;
         end
         plint_pkg::ST_WALK: begin
            if (!walk_more) begin
               state_in = plint_pkg::ST_PREP;
            end
         end
         plint_pkg::ST_PREP: begin
            state_in = plint_pkg::ST_DIV;
         end
         plint_pkg::ST_DIV: begin
            if (md_done) begin
               state_in = plint_pkg::ST_DONE;
            end
         end
         plint_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = plint_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = plint_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath next values
   always_comb begin
      req_stall   = 1'b1;
      ram_rd_addr = '0;
      md_start    = 1'b0;
      query_in    = query_ff;
      idx_in      = idx_ff;
      prev_x_in   = prev_x_ff;
      prev_y_in   = prev_y_ff;
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      neg_in      = neg_ff;
      res_in      = res_ff;
      case (state_ff)
         plint_pkg::ST_IDLE: begin
            // first knot is read while waiting, so it is ready on acceptance
            req_stall = 1'b0;
            if (req_accept) begin
               query_in = req_query_x;
            end
         end
         plint_pkg::ST_FIRST: begin
            ram_rd_addr = last_idx;
            prev_x_in   = rd_x;
            prev_y_in   = rd_y;
            res_in      = rd_y;
         end
         plint_pkg::ST_LAST: begin
            ram_rd_addr = IDXW'(1);
            idx_in      = IDXW'(1);
            res_in      = rd_y;
         end
         plint_pkg::ST_WALK: begin
            // advance one knot a cycle until the query is not above it
            ram_rd_addr = idx_ff + IDXW'(1);
            if (walk_more) begin
               prev_x_in = rd_x;
               prev_y_in = rd_y;
               idx_in    = idx_ff + IDXW'(1);
            end else begin
               cur_x_in = rd_x;
               cur_y_in = rd_y;
            end
         end
         plint_pkg::ST_PREP: begin
            md_start = 1'b1;
            neg_in   = diff_up[VALUE_WIDTH];
         end
         plint_pkg::ST_DIV: begin
            if (md_done) begin
               res_in = neg_ff ? prev_y_ff - md_quot : prev_y_ff + md_quot;
            end
         end
         plint_pkg::ST_DONE: begin
            req_stall = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Output register: fill from a finished evaluate, hold while stalled
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_result_y_in = rsp_result_y_ff;
      if (state_ff == plint_pkg::ST_DONE && rsp_free) begin
         rsp_valid_in    = 1'b1;
         rsp_result_y_in = res_ff;
      end
   end

   assign knot_count_in = csr_write_en ? csr_write_data : knot_count_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= plint_pkg::ST_IDLE;
         knot_count_ff <= plint_pkg::KNOT_COUNT_WIDTH'(plint_pkg::MIN_KNOTS);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         knot_count_ff <= knot_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      query_ff        <= query_in;
      idx_ff          <= idx_in;
      prev_x_ff       <= prev_x_in;
      prev_y_ff       <= prev_y_in;
      cur_x_ff        <= cur_x_in;
      cur_y_ff        <= cur_y_in;
      neg_ff          <= neg_in;
      res_ff          <= res_in;
      rsp_result_y_ff <= rsp_result_y_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_result_y = $signed(rsp_result_y_ff);

   // Checks
   `PLINT_ASSERT_NEXT(a_eval_starts_walk, clock, reset,
      req_valid && !req_stall && req_command == plint_pkg::CMD_EVAL,
      state_ff == plint_pkg::ST_FIRST, "accepted evaluate did not start the table read")
   `PLINT_ASSERT_IMPL(a_walk_in_range, clock, reset, state_ff == plint_pkg::ST_WALK,
      idx_ff <= last_idx && idx_ff != '0, "knot walk left the knots in use")
   `PLINT_ASSERT_IMPL(a_div_done_expected, clock, reset, md_done,
      state_ff == plint_pkg::ST_DIV, "divider finished outside the divide state")

endmodule
